>>> rtl/aosm_pkg.sv
// Package: payload types, trig table entries and their rounding helper.
`default_nettype none
package aosm_pkg;

    typedef struct packed {
        logic signed [31:0] sep_x;
        logic signed [31:0] sep_y;
        logic signed [31:0] sep_z;
        logic [30:0] a_half_x;
        logic [30:0] a_half_y;
        logic [30:0] a_half_z;
        logic [30:0] b_half_x;
        logic [30:0] b_half_y;
        logic [30:0] b_half_z;
        logic [15:0] b_yaw;
    } aosm_in_t;

    typedef struct packed {
        logic hit;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
        logic signed [31:0] push_z;
        logic [2:0] best_axis;
    } aosm_out_t;

    localparam int AXES = 6;
    localparam int MAG_W = 72;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q = 64'd843314857;

    // Running per-axis record passed along the chain of cells.
    typedef struct packed {
        logic        live;
        logic        miss;
        logic [MAG_W-1:0] best;
        logic [2:0]  best_k;
        logic        flip;
    } aosm_acc_t;

    function automatic logic [63:0] poly_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [127:0] p;
        begin
            p = x * x; x2 = p[93:30];
            t = Q30_ONE - x2 / 72;
            p = x2 * t; t = Q30_ONE - p[93:30] / 42;
            p = x2 * t; t = Q30_ONE - p[93:30] / 20;
            p = x2 * t; t = Q30_ONE - p[93:30] / 6;
            p = x * t;
            return p[93:30];
        end
    endfunction

    function automatic logic [63:0] poly_cos(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [127:0] p;
        begin
            p = x * x; x2 = p[93:30];
            t = Q30_ONE - x2 / 90;
            p = x2 * t; t = Q30_ONE - p[93:30] / 56;
            p = x2 * t; t = Q30_ONE - p[93:30] / 30;
            p = x2 * t; t = Q30_ONE - p[93:30] / 12;
            p = x2 * t; t = Q30_ONE - p[93:30] / 2;
            return t;
        end
    endfunction

    function automatic logic signed [31:0] q30_frac(input logic [63:0] v, input int fb);
        logic [63:0] r;
        begin
            r = (v + (64'd1 << (29 - fb))) >> (30 - fb);
            return r[31:0];
        end
    endfunction

    // sin in the high half, cos in the low half, at table index idx.
    function automatic logic [63:0] trig_entry(input int idx, input int depth,
                                               input int fb);
        logic [63:0] e, oct, r, x;
        logic signed [31:0] sq, cq, sn, cs;
        begin
            e = 64'(idx) * 8;
            oct = (e / 64'(depth)) & 64'd7;
            r = e % 64'(depth);
            if (!oct[0]) begin
                x = r * PI_Q / 64'(depth);
                sq = q30_frac(poly_sin(x), fb);
                cq = q30_frac(poly_cos(x), fb);
            end else begin
                x = (64'(depth) - r) * PI_Q / 64'(depth);
                sq = q30_frac(poly_cos(x), fb);
                cq = q30_frac(poly_sin(x), fb);
            end
            case (oct[2:1])
                2'd0:    begin sn = sq;  cs = cq;  end
                2'd1:    begin sn = cq;  cs = -sq; end
                2'd2:    begin sn = -sq; cs = -cq; end
                default: begin sn = -cq; cs = sq;  end
            endcase
            return {sn, cs};
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/aosm_cell.sv
// One axis cell: projects, compares overlap and passes the running best on.
`default_nettype none
module aosm_cell #(
    parameter int FB = 16,
    parameter int K = 0
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire aosm_pkg::aosm_in_t item_in,
    input  wire logic signed [31:0] sn_in,
    input  wire logic signed [31:0] cs_in,
    input  wire aosm_pkg::aosm_acc_t acc_in,
    output aosm_pkg::aosm_in_t item_out,
    output logic signed [31:0] sn_out,
    output logic signed [31:0] cs_out,
    output aosm_pkg::aosm_acc_t acc_out
);
    import aosm_pkg::*;

    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (FB - 1);
    localparam logic signed [32:0] ONE = 33'sd1 <<< FB;

    // stage 1: products
    logic signed [65:0] d0_reg, d1_reg, d2_reg;
    logic [63:0] ra0_reg, ra1_reg, ra2_reg, rb0_reg, rb1_reg, rb2_reg;
    aosm_in_t item_reg;
    logic signed [31:0] sn_reg, cs_reg;
    aosm_acc_t acc_reg;
    logic live_reg;

    logic signed [32:0] n0, n1, n2, b0, b1, b2;
    always_comb
    begin
        n0 = '0; n1 = '0; n2 = '0; b0 = '0; b1 = '0; b2 = '0;
        case (K)
            0: begin n0 = ONE; b0 = 33'(cs_in); b1 = '0; b2 = 33'(sn_in); end
            1: begin n1 = ONE; b1 = ONE; end
            2: begin n2 = ONE; b0 = -33'(sn_in); b2 = 33'(cs_in); end
            3: begin n0 = 33'(cs_in); n2 = -33'(sn_in); b0 = ONE; end
            4: begin n1 = ONE; b1 = ONE; end
            default: begin n0 = 33'(sn_in); n2 = 33'(cs_in); b2 = ONE; end
        endcase
    end

    function automatic logic [32:0] mag(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= 1'b0;
        else if (en)
            live_reg <= acc_in.live;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_in; sn_reg <= sn_in; cs_reg <= cs_in; acc_reg <= acc_in;
            d0_reg <= 66'(item_in.sep_x) * 66'(n0);
            d1_reg <= 66'(item_in.sep_y) * 66'(n1);
            d2_reg <= 66'(item_in.sep_z) * 66'(n2);
            ra0_reg <= 64'({1'b0, item_in.a_half_x}) * 64'(mag(n0));
            ra1_reg <= 64'({1'b0, item_in.a_half_y}) * 64'(mag(n1));
            ra2_reg <= 64'({1'b0, item_in.a_half_z}) * 64'(mag(n2));
            rb0_reg <= 64'({1'b0, item_in.b_half_x}) * 64'(mag(b0));
            rb1_reg <= 64'({1'b0, item_in.b_half_y}) * 64'(mag(b1));
            rb2_reg <= 64'({1'b0, item_in.b_half_z}) * 64'(mag(b2));
        end
    end

    function automatic logic [MAG_W-1:0] rnd(input logic [MAG_W-1:0] p);
        return (p + HALF) >> FB;
    endfunction

    logic signed [67:0] dot;
    logic [MAG_W-1:0] center, total, ovl;
    aosm_acc_t acc_next;
    always_comb
    begin
        dot = 68'(d0_reg) + 68'(d1_reg) + 68'(d2_reg);
        center = rnd(dot[67] ? MAG_W'(-dot) : MAG_W'(dot));
        total = rnd(MAG_W'(ra0_reg)) + rnd(MAG_W'(ra1_reg)) + rnd(MAG_W'(ra2_reg))
              + rnd(MAG_W'(rb0_reg)) + rnd(MAG_W'(rb1_reg)) + rnd(MAG_W'(rb2_reg));
        ovl = total - center;
        acc_next = acc_reg;
        acc_next.live = live_reg;
        if (!acc_reg.miss)
        begin
            if (center > total)
                acc_next.miss = 1'b1;
            else if (K == 0 || ovl < acc_reg.best)
            begin
                acc_next.best = ovl;
                acc_next.best_k = 3'(K);
                acc_next.flip = !dot[67] && (dot != 0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_out <= item_reg; sn_out <= sn_reg; cs_out <= cs_reg;
            acc_out <= acc_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/aabb_obb_separating_axis_mtv_top.sv
// Top level: trig lookup, chain of six axis cells, push formation.
// A word enters every cycle unless a waiting result is stalled; registers: table,
// two per axis cell, push multiply, push output. A result-side stall with a word waiting freezes the whole chain.
`default_nettype none
module aabb_obb_separating_axis_mtv_top #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire aosm_pkg::aosm_in_t in_data,
    output logic out_valid,
    input  wire logic out_stall,
    output aosm_pkg::aosm_out_t out_data
);
    import aosm_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

    logic en;
    logic out_valid_reg;
    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    logic [63:0] trig_rom [SINE_TABLE_DEPTH];
    always_comb
    begin
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
            trig_rom[i] = trig_entry(i, SINE_TABLE_DEPTH, FRAC_BITS);
    end

    logic [31:0] idx_full;
    logic [IW-1:0] idx;
    assign idx_full = (32'(in_data.b_yaw) * 32'(SINE_TABLE_DEPTH)) >> 16;
    assign idx = idx_full[IW-1:0];

    aosm_in_t item_c [AXES+1];
    logic signed [31:0] sn_c [AXES+1];
    logic signed [31:0] cs_c [AXES+1];
    aosm_acc_t acc_c [AXES+1];
    logic v0_reg;
    aosm_in_t item0_reg;
    logic signed [31:0] sn0_reg, cs0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item0_reg <= in_data;
            sn0_reg <= trig_rom[idx][63:32];
            cs0_reg <= trig_rom[idx][31:0];
        end
    end

    assign item_c[0] = item0_reg;
    assign sn_c[0] = sn0_reg;
    assign cs_c[0] = cs0_reg;
    assign acc_c[0] = '{live: v0_reg, miss: 1'b0, best: '0, best_k: 3'd0, flip: 1'b0};

    for (genvar k = 0; k < AXES; k++)
    begin : g_cell
        aosm_cell #(.FB(FRAC_BITS), .K(k)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .item_in(item_c[k]), .sn_in(sn_c[k]), .cs_in(cs_c[k]), .acc_in(acc_c[k]),
            .item_out(item_c[k+1]), .sn_out(sn_c[k+1]), .cs_out(cs_c[k+1]),
            .acc_out(acc_c[k+1])
        );
    end

    // axis components of the winner
    aosm_acc_t fin;
    logic signed [32:0] n0, n1, n2;
    always_comb
    begin
        fin = acc_c[AXES];
        n0 = '0; n1 = '0; n2 = '0;
        case (fin.best_k)
            3'd0: n0 = ONE;
            3'd1: n1 = ONE;
            3'd2: n2 = ONE;
            3'd3: begin n0 = 33'(cs_c[AXES]); n2 = -33'(sn_c[AXES]); end
            3'd4: n1 = ONE;
            default: begin n0 = 33'(sn_c[AXES]); n2 = 33'(cs_c[AXES]); end
        endcase
    end

    // best is at most six rounded radii of 2^31 each, so 34 bits; one
    // 34x33 product per component
    logic [66:0] p0_reg, p1_reg, p2_reg;
    logic neg0_reg, neg1_reg, neg2_reg, hit_reg, vp_reg;
    logic [2:0] k_reg;

    function automatic logic [32:0] mag(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= 1'b0;
        else if (en)
            vp_reg <= fin.live;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= 67'(fin.best[33:0]) * 67'(mag(n0));
            p1_reg <= 67'(fin.best[33:0]) * 67'(mag(n1));
            p2_reg <= 67'(fin.best[33:0]) * 67'(mag(n2));
            neg0_reg <= n0[32] != fin.flip;
            neg1_reg <= n1[32] != fin.flip;
            neg2_reg <= n2[32] != fin.flip;
            hit_reg <= !fin.miss;
            k_reg <= fin.best_k;
        end
    end

    function automatic logic [31:0] push(input logic [66:0] p, input logic neg);
        logic [66:0] m;
        begin
            m = (p + (67'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (m == 0)
                return '0;
            else if (neg)
                return (m > 67'h80000000) ? 32'h80000000 : 32'(-m[31:0]);
            else
                return (m > 67'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        end
    endfunction

    aosm_out_t res;
    always_comb
    begin
        res = '0;
        if (hit_reg)
        begin
            res.hit = 1'b1;
            res.push_x = push(p0_reg, neg0_reg);
            res.push_y = push(p1_reg, neg1_reg);
            res.push_z = push(p2_reg, neg2_reg);
            res.best_axis = k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= res;
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

>>> rtl/aosm_checker.sv
// Port checker for the top level, with its bind.
`default_nettype none
module aosm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire aosm_pkg::aosm_out_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled word changed");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.push_x == 0 && out_data.push_y == 0
            && out_data.push_z == 0 && out_data.best_axis == 0)
        else $error("miss word not zero");
    a_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.best_axis <= 3'd5)
        else $error("axis out of range");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
endmodule

bind aabb_obb_separating_axis_mtv_top aosm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

>>> tb/aosm_checker.sv
// Checker: watches both channels, predicts each result word and compares.
`timescale 1ns / 1ps
module aosm_tb_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_stall,
    input  wire aosm_pkg::aosm_in_t in_data,
    input  wire logic out_valid,
    input  wire logic out_stall,
    input  wire aosm_pkg::aosm_out_t out_data,
    output int fail_count,
    output int pending
);
    import aosm_pkg::*;

    localparam int DEPTH = 1024;
    localparam int FB = 16;
    localparam logic [63:0] QONE = 64'd1 << 30;
    localparam logic [63:0] QUARTER_PI = 64'd843314857;

    aosm_out_t expected_q[$];

    function automatic logic [63:0] taylor_sin(input logic [63:0] x);
        logic [127:0] p;
        logic [63:0] x2, t;
        p = x * x; x2 = p >> 30;
        t = QONE - x2 / 72;
        p = x2 * t; t = QONE - (p >> 30) / 42;
        p = x2 * t; t = QONE - (p >> 30) / 20;
        p = x2 * t; t = QONE - (p >> 30) / 6;
        p = x * t;
        return p >> 30;
    endfunction

    function automatic logic [63:0] taylor_cos(input logic [63:0] x);
        logic [127:0] p;
        logic [63:0] x2, t;
        p = x * x; x2 = p >> 30;
        t = QONE - x2 / 90;
        p = x2 * t; t = QONE - (p >> 30) / 56;
        p = x2 * t; t = QONE - (p >> 30) / 30;
        p = x2 * t; t = QONE - (p >> 30) / 12;
        p = x2 * t; t = QONE - (p >> 30) / 2;
        return t;
    endfunction

    function automatic longint to_frac(input logic [63:0] v);
        return longint'((v + (64'd1 << (29 - FB))) >> (30 - FB));
    endfunction

    function automatic logic [127:0] round_mag(input logic [127:0] p);
        return (p + (128'd1 << (FB - 1))) >> FB;
    endfunction

    function automatic logic [127:0] abs_wide(input logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic aosm_out_t predict_mtv(input aosm_in_t w);
        logic [63:0] idx, e, oct, r, x;
        longint sq, cq, sn, cs, one;
        logic signed [127:0] sep [3];
        logic signed [127:0] ax [6][3];
        logic signed [127:0] bax [3][3];
        logic [127:0] ha [3], hb [3];
        logic signed [127:0] dot, bd, n;
        logic [127:0] best, centre, total, m;
        int best_k;
        bit flip, hit, neg;
        aosm_out_t res;
        one = longint'(1) << FB;
        sep[0] = w.sep_x; sep[1] = w.sep_y; sep[2] = w.sep_z;
        ha[0] = w.a_half_x; ha[1] = w.a_half_y; ha[2] = w.a_half_z;
        hb[0] = w.b_half_x; hb[1] = w.b_half_y; hb[2] = w.b_half_z;
        idx = (64'(w.b_yaw) * DEPTH) >> 16;
        e = idx * 8;
        oct = (e / DEPTH) & 7;
        r = e % DEPTH;
        if (!oct[0])
        begin
            x = r * QUARTER_PI / DEPTH;
            sq = to_frac(taylor_sin(x)); cq = to_frac(taylor_cos(x));
        end
        else
        begin
            x = (DEPTH - r) * QUARTER_PI / DEPTH;
            sq = to_frac(taylor_cos(x)); cq = to_frac(taylor_sin(x));
        end
        case (oct[2:1])
            2'd0: begin sn = sq; cs = cq; end
            2'd1: begin sn = cq; cs = -sq; end
            2'd2: begin sn = -sq; cs = -cq; end
            default: begin sn = -cq; cs = sq; end
        endcase
        bax[0][0] = cs; bax[0][1] = 0; bax[0][2] = -sn;
        bax[1][0] = 0; bax[1][1] = one; bax[1][2] = 0;
        bax[2][0] = sn; bax[2][1] = 0; bax[2][2] = cs;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
            begin
                ax[k][j] = (k == j) ? one : 0;
                ax[3 + k][j] = bax[k][j];
            end
        best = '1; best_k = 0; flip = 0; hit = 1;
        for (int k = 0; k < 6; k++)
        begin
            dot = sep[0] * ax[k][0] + sep[1] * ax[k][1] + sep[2] * ax[k][2];
            centre = round_mag(abs_wide(dot));
            total = 0;
            for (int j = 0; j < 3; j++)
            begin
                bd = (k < 3) ? bax[j][k] : ((k - 3 == j) ? one : 0);
                total += round_mag(ha[j] * abs_wide(ax[k][j]));
                total += round_mag(hb[j] * abs_wide(bd));
            end
            if (centre > total)
            begin
                hit = 0;
                break;
            end
            if (total - centre < best)
            begin
                best = total - centre; best_k = k; flip = dot > 0;
            end
        end
        res = '0;
        if (!hit)
            return res;
        res.hit = 1'b1;
        res.best_axis = 3'(best_k);
        for (int j = 0; j < 3; j++)
        begin
            n = ax[best_k][j];
            m = round_mag(abs_wide(n) * best);
            neg = (n < 0) != flip;
            if (m != 0 && neg)
            begin
                if (m > 128'h8000_0000) m = 128'h8000_0000;
                m = -m;
            end
            else if (m > 128'h7FFF_FFFF)
                m = 128'h7FFF_FFFF;
            case (j)
                0: res.push_x = m[31:0];
                1: res.push_y = m[31:0];
                default: res.push_z = m[31:0];
            endcase
        end
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        aosm_out_t exp_w;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q = {expected_q, predict_mtv(in_data)};
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word %p", out_data);
                end
                else
                begin
                    exp_w = expected_q.pop_front();
                    if (exp_w !== out_data)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", exp_w, out_data);
                    end
                end
            end
        end
    end
endmodule

>>> tb/tb_aabb_obb_separating_axis_mtv_top.sv
// Testbench top: drives box pairs through the block and reports the verdict.
`timescale 1ns / 1ps
module tb_aabb_obb_separating_axis_mtv_top;
    import aosm_pkg::*;

    localparam int N_RANDOM = 1330;
    localparam int WATCHDOG = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    aosm_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    aosm_out_t out_data;
    int fail_count, pending;
    int idle_cycles = 0;
    bit drained = 0;

    always #2 clk = ~clk;

    aabb_obb_separating_axis_mtv_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    aosm_tb_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver stall pattern: each cycle picks heavy, light or no stalling
    always @(posedge clk)
    begin
        int mode;
        mode = ($urandom_range(0, 299) / 100);
        if (mode == 0) out_stall <= ($urandom_range(0, 3) == 0);
        else if (mode == 1) out_stall <= ($urandom_range(0, 1) == 0);
        else out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [30:0] rand_half();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(0, 1 << 20));
            default: return 31'($urandom_range(0, 1 << 24));
        endcase
    endfunction

    function automatic logic [31:0] rand_sep();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    function automatic aosm_in_t random_pair();
        aosm_in_t w;
        w.sep_x = rand_sep(); w.sep_y = rand_sep(); w.sep_z = rand_sep();
        w.a_half_x = rand_half(); w.a_half_y = rand_half(); w.a_half_z = rand_half();
        w.b_half_x = rand_half(); w.b_half_y = rand_half(); w.b_half_z = rand_half();
        w.b_yaw = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 7) * 16'h2000)
                                            : 16'($urandom());
        return w;
    endfunction

    task automatic send_word(input aosm_in_t w);
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    aosm_in_t dw;
    int burst;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, every axis winning, touching, flip signs, yaw octants
        dw = '0;
        send_word(dw);
        dw.a_half_x = '1; dw.a_half_y = '1; dw.a_half_z = '1;
        dw.b_half_x = '1; dw.b_half_y = '1; dw.b_half_z = '1;
        send_word(dw);
        dw.sep_x = 32'h8000_0000; dw.sep_y = 32'h7FFF_FFFF; dw.sep_z = 32'hFFFF_FFFF;
        send_word(dw);
        dw = '0;
        dw.a_half_x = 31'h10000; dw.a_half_y = 31'h10000; dw.a_half_z = 31'h10000;
        dw.b_half_x = 31'h10000; dw.b_half_y = 31'h10000; dw.b_half_z = 31'h10000;
        dw.sep_x = 32'h20000;
        send_word(dw);
        dw.sep_x = 32'h20001;
        send_word(dw);
        dw.sep_x = -32'sh18000;
        send_word(dw);
        dw.sep_x = 32'h0; dw.sep_y = 32'h18000;
        send_word(dw);
        dw.sep_y = 0; dw.sep_z = -32'sh1C000;
        send_word(dw);
        for (int o = 0; o < 16; o++)
        begin
            dw.sep_x = 32'h8000; dw.sep_z = 32'h4000;
            dw.b_yaw = 16'(o * 16'h1000 + (o & 1) * 16'h0FFF);
            dw.b_half_x = 31'h30000; dw.b_half_z = 31'h8000;
            send_word(dw);
        end
        drop_valid();
        for (int i = 0; i < N_RANDOM;)
        begin
            burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
            for (int b = 0; b < burst && i < N_RANDOM; b++, i++)
                send_word(random_pair());
            if (!drained && i > N_RANDOM / 2)
            begin
                drained = 1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            else
                repeat ($urandom_range(1, 6)) drop_valid();
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> aabb_obb_separating_axis_mtv_top.f
rtl/aosm_pkg.sv
rtl/aosm_cell.sv
rtl/aabb_obb_separating_axis_mtv_top.sv
rtl/aosm_checker.sv
tb/aosm_checker.sv
tb/tb_aabb_obb_separating_axis_mtv_top.sv
